FILE: design/jac_pkg.sv
// ----------------------------------------------------------------------------
// jac_pkg: shared definitions for the joystick axis conditioner
// Widths, constants, command and status bundles used by the controller and
// the datapath.
// ----------------------------------------------------------------------------
package jac_pkg;

   // Sample and curve formats
   localparam int SAMPLE_BITS     = 12;
   localparam int CURVE_FRAC_BITS = 8;
   localparam int CURVE_BITS      = 11;
   localparam int CURVE_INT_BITS  = CURVE_BITS - CURVE_FRAC_BITS;
   localparam int DZ_BITS         = SAMPLE_BITS - 1;

   // Internal arithmetic widths
   localparam int SW        = SAMPLE_BITS + 2;      // signed band arithmetic
   localparam int MW        = SAMPLE_BITS + 1;      // magnitudes of num / den
   localparam int Q_BITS    = 24;                   // fraction bits of the curve
   localparam int QV_W      = Q_BITS + 1;           // Q values up to 1.0
   localparam int PROD_W    = 2 * QV_W;
   localparam int SQ_W      = 2 * Q_BITS + 1;       // root operand
   localparam int AXIS_W    = 8;
   localparam int MAG_W     = 7;
   localparam int LIN_Q_BITS = MAG_W;               // quotient bits, linear path
   localparam int LIN_X_W   = MW + 8;               // 200*an + ad
   localparam int STEP_W    = $clog2(Q_BITS + 1);
   localparam int LOOP_W    = $clog2(CURVE_BITS);

   // Configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = SAMPLE_BITS;

   // Constants
   localparam logic [MAG_W-1:0]       MAG_FULL     = MAG_W'(100);
   localparam logic [LIN_X_W-1:0]     LIN_SCALE    = LIN_X_W'(200);
   localparam logic [SAMPLE_BITS-1:0] CENTER_RESET = SAMPLE_BITS'(1) << (SAMPLE_BITS - 1);
   localparam logic [SAMPLE_BITS-1:0] MAX_RESET    = '1;
   localparam logic [CURVE_BITS-1:0]  POWER_ONE    = CURVE_BITS'(1) << CURVE_FRAC_BITS;
   localparam logic [QV_W-1:0]        QV_ONE       = QV_W'(1) << Q_BITS;
   localparam logic [PROD_W-1:0]      ROUND_HALF   = PROD_W'(1) << (Q_BITS - 1);
   localparam logic [SQ_W-1:0]        SQ_TOP_BIT   = SQ_W'(1) << (2 * Q_BITS);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_AXIS_MIN    = 3'd0,
      CSR_AXIS_CENTER = 3'd1,
      CSR_AXIS_MAX    = 3'd2,
      CSR_DEAD_ZONE   = 3'd3,
      CSR_CURVE_POWER = 3'd4,
      CSR_FLIP_SIGN   = 3'd5
   } csr_index_type;

   typedef enum logic [1:0] {
      MUL_ACC_BASE,
      MUL_BASE_BASE,
      MUL_ACC_ROOT,
      MUL_ACC_SCALE
   } mul_sel_type;

   typedef enum logic [1:0] {
      MAG_SRC_ZERO,
      MAG_SRC_FULL,
      MAG_SRC_LIN,
      MAG_SRC_ROUND
   } mag_src_type;

   typedef struct packed {
      logic        load;
      logic        setup;
      logic        div_init;
      logic        div_step;
      logic        pow_init;
      logic        mul_en;
      mul_sel_type mul_sel;
      logic        acc_wr;
      logic        base_wr;
      logic        sq_init;
      logic        sq_step;
      logic        rt_wr;
      logic        mag_wr;
      mag_src_type mag_src;
      logic        out_load;
   } jac_cmd_type;

   typedef struct packed {
      logic                  zero;
      logic                  sat;
      logic                  curve;
      logic [CURVE_BITS-1:0] power;
   } jac_status_type;

endpackage

FILE: design/jac_ctrl.sv
// ----------------------------------------------------------------------------
// jac_ctrl: sequencer of the joystick axis conditioner
// Walks one sample through band setup, the shared divider, the power curve
// (square-and-multiply, then repeated roots) and the output handoff.
// ----------------------------------------------------------------------------
module jac_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  jac_pkg::jac_status_type status,
   output jac_pkg::jac_cmd_type    cmd
);

   typedef enum logic [15:0] {
      ST_IDLE   = 16'b0000_0000_0000_0001,
      ST_SETUP  = 16'b0000_0000_0000_0010,
      ST_DINIT  = 16'b0000_0000_0000_0100,
      ST_DIV    = 16'b0000_0000_0000_1000,
      ST_LIN    = 16'b0000_0000_0001_0000,
      ST_PINIT  = 16'b0000_0000_0010_0000,
      ST_IMUL   = 16'b0000_0000_0100_0000,
      ST_IACC   = 16'b0000_0000_1000_0000,
      ST_ISQ    = 16'b0000_0001_0000_0000,
      ST_SQINIT = 16'b0000_0010_0000_0000,
      ST_SQ     = 16'b0000_0100_0000_0000,
      ST_FMUL   = 16'b0000_1000_0000_0000,
      ST_FACC   = 16'b0001_0000_0000_0000,
      ST_SCALE  = 16'b0010_0000_0000_0000,
      ST_ROUND  = 16'b0100_0000_0000_0000,
      ST_DONE   = 16'b1000_0000_0000_0000
   } state_type;

   state_type                               state_ff, state_in;
   logic [jac_pkg::STEP_W-1:0]              step_ff, step_in;
   logic [jac_pkg::LOOP_W-1:0]              loop_ff, loop_in;
   logic [jac_pkg::CURVE_INT_BITS-1:0]      ipw_ff, ipw_in;
   logic [jac_pkg::CURVE_FRAC_BITS-1:0]     fpw_ff, fpw_in;
   logic                                    rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      loop_in  = loop_ff;
      ipw_in   = ipw_ff;
      fpw_in   = fpw_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            cmd.setup = 1'b1;
            state_in  = ST_DINIT;
         end
         ST_DINIT: begin
            if (status.zero) begin
               cmd.mag_wr  = 1'b1;
               cmd.mag_src = jac_pkg::MAG_SRC_ZERO;
               state_in    = ST_DONE;
            end else if (status.sat) begin
               cmd.mag_wr  = 1'b1;
               cmd.mag_src = jac_pkg::MAG_SRC_FULL;
               state_in    = ST_DONE;
            end else begin
               cmd.div_init = 1'b1;
               step_in      = status.curve ? jac_pkg::STEP_W'(jac_pkg::Q_BITS - 1)
                                           : jac_pkg::STEP_W'(jac_pkg::LIN_Q_BITS - 1);
               state_in     = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (step_ff == '0) begin
               state_in = status.curve ? ST_PINIT : ST_LIN;
            end else begin
               step_in = step_ff - 1'b1;
            end
         end
         ST_LIN: begin
            cmd.mag_wr  = 1'b1;
            cmd.mag_src = jac_pkg::MAG_SRC_LIN;
            state_in    = ST_DONE;
         end
         ST_PINIT: begin
            cmd.pow_init = 1'b1;
            ipw_in   = status.power[jac_pkg::CURVE_BITS-1:jac_pkg::CURVE_FRAC_BITS];
            fpw_in   = status.power[jac_pkg::CURVE_FRAC_BITS-1:0];
            loop_in  = jac_pkg::LOOP_W'(jac_pkg::CURVE_INT_BITS - 1);
            state_in = ST_IMUL;
         end
         // integer part of the exponent, LSB first
         ST_IMUL: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = jac_pkg::MUL_ACC_BASE;
            state_in    = ST_IACC;
         end
         ST_IACC: begin
            cmd.acc_wr  = ipw_ff[0];
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = jac_pkg::MUL_BASE_BASE;
            state_in    = ST_ISQ;
         end
         ST_ISQ: begin
            cmd.base_wr = 1'b1;
            ipw_in      = ipw_ff >> 1;
            if (loop_ff == '0) begin
               loop_in  = jac_pkg::LOOP_W'(jac_pkg::CURVE_FRAC_BITS - 1);
               state_in = ST_SQINIT;
            end else begin
               loop_in  = loop_ff - 1'b1;
               state_in = ST_IMUL;
            end
         end
         // fraction bits: one root per bit, MSB first
         ST_SQINIT: begin
            cmd.sq_init = 1'b1;
            step_in     = jac_pkg::STEP_W'(jac_pkg::Q_BITS);
            state_in    = ST_SQ;
         end
         ST_SQ: begin
            cmd.sq_step = 1'b1;
            if (step_ff == '0) begin
               state_in = ST_FMUL;
            end else begin
               step_in = step_ff - 1'b1;
            end
         end
         ST_FMUL: begin
            cmd.rt_wr   = 1'b1;
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = jac_pkg::MUL_ACC_ROOT;
            state_in    = ST_FACC;
         end
         ST_FACC: begin
            cmd.acc_wr = fpw_ff[jac_pkg::CURVE_FRAC_BITS-1];
            fpw_in     = fpw_ff << 1;
            if (loop_ff == '0) begin
               state_in = ST_SCALE;
            end else begin
               loop_in  = loop_ff - 1'b1;
               state_in = ST_SQINIT;
            end
         end
         ST_SCALE: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = jac_pkg::MUL_ACC_SCALE;
            state_in    = ST_ROUND;
         end
         ST_ROUND: begin
            cmd.mag_wr  = 1'b1;
            cmd.mag_src = jac_pkg::MAG_SRC_ROUND;
            state_in    = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output beat valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         loop_ff      <= '0;
         ipw_ff       <= '0;
         fpw_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         loop_ff      <= loop_in;
         ipw_ff       <= ipw_in;
         fpw_ff       <= fpw_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

FILE: design/jac_datapath.sv
// ----------------------------------------------------------------------------
// jac_datapath: arithmetic of the joystick axis conditioner
// Configuration registers, band logic, shift-subtract divider, shared
// multiplier, bit-serial square root and the output beat registers.
// ----------------------------------------------------------------------------
module jac_datapath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_we,
   input  logic [jac_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [jac_pkg::CSR_DATA_W-1:0]        csr_wdata,
   input  logic [jac_pkg::SAMPLE_BITS-1:0]       req_sample,
   input  jac_pkg::jac_cmd_type                  cmd,
   output jac_pkg::jac_status_type               status,
   output logic signed [jac_pkg::AXIS_W-1:0]     rsp_axis_hundredths,
   output logic                                  rsp_changed
);

   // configuration
   logic [jac_pkg::SAMPLE_BITS-1:0] cfg_min_ff, cfg_center_ff, cfg_max_ff;
   logic [jac_pkg::DZ_BITS-1:0]     cfg_dz_ff;
   logic [jac_pkg::CURVE_BITS-1:0]  cfg_power_ff;
   logic                            cfg_flip_ff;

   // item registers
   logic [jac_pkg::SAMPLE_BITS-1:0] sample_ff;
   logic [jac_pkg::MW-1:0]          an_ff, ad_ff;
   logic                            neg_ff, zero_ff;
   logic [jac_pkg::SW-1:0]          rem_ff, dv_ff;
   logic [jac_pkg::Q_BITS-1:0]      qr_ff;
   logic [jac_pkg::QV_W-1:0]        acc_ff, base_ff, rt_ff;
   logic [jac_pkg::PROD_W-1:0]      prod_ff;
   logic [jac_pkg::SQ_W-1:0]        sx_ff, sr_ff, sb_ff;
   logic [jac_pkg::MAG_W-1:0]       mag_ff;
   logic signed [jac_pkg::AXIS_W-1:0] axis_ff, last_ff;
   logic                            changed_ff;

   // combinational
   logic signed [jac_pkg::SW-1:0]   s_x, mn_x, c_x, mx_x, dz_x, lo, hi, num, den;
   logic                            in_band, above;
   logic [jac_pkg::LIN_X_W-1:0]     lin_x;
   logic [jac_pkg::SW:0]            rem_sh, dv_ext, rem_diff;
   logic                            div_ge;
   logic [jac_pkg::QV_W-1:0]        mul_a, mul_b, sq_res;
   logic [jac_pkg::SQ_W:0]          sq_t;
   logic                            sq_ge;
   logic [jac_pkg::PROD_W-1:0]      rnd;
   logic [jac_pkg::MAG_W-1:0]       lin_q, mag_in;
   logic signed [jac_pkg::AXIS_W-1:0] mag_s, val_a, val;

   // configuration writes; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_min_ff    <= '0;
         cfg_center_ff <= jac_pkg::CENTER_RESET;
         cfg_max_ff    <= jac_pkg::MAX_RESET;
         cfg_dz_ff     <= '0;
         cfg_power_ff  <= jac_pkg::POWER_ONE;
         cfg_flip_ff   <= 1'b0;
      end else if (csr_we) begin
         case (jac_pkg::csr_index_type'(csr_index))
            jac_pkg::CSR_AXIS_MIN:    cfg_min_ff    <= csr_wdata;
            jac_pkg::CSR_AXIS_CENTER: cfg_center_ff <= csr_wdata;
            jac_pkg::CSR_AXIS_MAX:    cfg_max_ff    <= csr_wdata;
            jac_pkg::CSR_DEAD_ZONE:   cfg_dz_ff     <= csr_wdata[jac_pkg::DZ_BITS-1:0];
            jac_pkg::CSR_CURVE_POWER: cfg_power_ff  <= csr_wdata[jac_pkg::CURVE_BITS-1:0];
            jac_pkg::CSR_FLIP_SIGN:   cfg_flip_ff   <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // band edges, dividend and divisor
   always_comb begin
      s_x  = jac_pkg::SW'(sample_ff);
      mn_x = jac_pkg::SW'(cfg_min_ff);
      c_x  = jac_pkg::SW'(cfg_center_ff);
      mx_x = jac_pkg::SW'(cfg_max_ff);
      dz_x = jac_pkg::SW'(cfg_dz_ff);
      lo   = c_x - dz_x;
      hi   = c_x + dz_x;
      in_band = (s_x > lo) && (s_x < hi);
      above   = s_x > c_x;
      if (above) begin
         num = s_x - hi;
         den = mx_x - hi;
      end else begin
         num = s_x - lo;
         den = lo - mn_x;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         sample_ff <= req_sample;
      end
      if (cmd.setup) begin
         an_ff   <= jac_pkg::MW'(num[jac_pkg::SW-1] ? -num : num);
         ad_ff   <= jac_pkg::MW'(den[jac_pkg::SW-1] ? -den : den);
         neg_ff  <= num[jac_pkg::SW-1] ^ den[jac_pkg::SW-1];
         zero_ff <= in_band || (num == '0);
      end
   end

   assign status.zero  = zero_ff;
   assign status.sat   = an_ff >= ad_ff;
   assign status.curve = cfg_power_ff > jac_pkg::POWER_ONE;
   assign status.power = cfg_power_ff;

   // restoring divider, one quotient bit per step
   assign lin_x    = jac_pkg::LIN_X_W'(an_ff) * jac_pkg::LIN_SCALE + jac_pkg::LIN_X_W'(ad_ff);
   assign rem_sh   = {rem_ff, qr_ff[jac_pkg::Q_BITS-1]};
   assign dv_ext   = {1'b0, dv_ff};
   assign div_ge   = rem_sh >= dv_ext;
   assign rem_diff = rem_sh - dv_ext;

   always_ff @(posedge clock) begin
      if (cmd.div_init) begin
         if (status.curve) begin
            // an * 2^Q / ad
            rem_ff <= jac_pkg::SW'(an_ff);
            qr_ff  <= '0;
            dv_ff  <= jac_pkg::SW'(ad_ff);
         end else begin
            // (200*an + ad) / (2*ad), rounds half away from zero
            rem_ff <= jac_pkg::SW'(lin_x[jac_pkg::LIN_X_W-1:jac_pkg::LIN_Q_BITS]);
            qr_ff  <= {lin_x[jac_pkg::LIN_Q_BITS-1:0],
                       (jac_pkg::Q_BITS - jac_pkg::LIN_Q_BITS)'(0)};
            dv_ff  <= jac_pkg::SW'({ad_ff, 1'b0});
         end
      end else if (cmd.div_step) begin
         rem_ff <= div_ge ? rem_diff[jac_pkg::SW-1:0] : rem_sh[jac_pkg::SW-1:0];
         qr_ff  <= {qr_ff[jac_pkg::Q_BITS-2:0], div_ge};
      end
   end

   // shared multiplier, product registered
   always_comb begin
      case (cmd.mul_sel)
         jac_pkg::MUL_ACC_BASE:  begin mul_a = acc_ff;  mul_b = base_ff; end
         jac_pkg::MUL_BASE_BASE: begin mul_a = base_ff; mul_b = base_ff; end
         jac_pkg::MUL_ACC_ROOT:  begin mul_a = acc_ff;  mul_b = sq_res;  end
         jac_pkg::MUL_ACC_SCALE: begin
            mul_a = acc_ff;
            mul_b = jac_pkg::QV_W'(jac_pkg::MAG_FULL);
         end
         default:                begin mul_a = acc_ff;  mul_b = base_ff; end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         prod_ff <= mul_a * mul_b;
      end
      if (cmd.pow_init) begin
         acc_ff  <= jac_pkg::QV_ONE;
         base_ff <= jac_pkg::QV_W'(qr_ff);
         rt_ff   <= jac_pkg::QV_W'(qr_ff);
      end else begin
         if (cmd.acc_wr) begin
            acc_ff <= prod_ff[jac_pkg::Q_BITS +: jac_pkg::QV_W];
         end
         if (cmd.base_wr) begin
            base_ff <= prod_ff[jac_pkg::Q_BITS +: jac_pkg::QV_W];
         end
         if (cmd.rt_wr) begin
            rt_ff <= sq_res;
         end
      end
   end

   // bit-serial floor square root of rt * 2^Q
   assign sq_res = sr_ff[jac_pkg::QV_W-1:0];
   assign sq_t   = {1'b0, sr_ff} + {1'b0, sb_ff};
   assign sq_ge  = {1'b0, sx_ff} >= sq_t;

   always_ff @(posedge clock) begin
      if (cmd.sq_init) begin
         sx_ff <= {rt_ff, jac_pkg::Q_BITS'(0)};
         sr_ff <= '0;
         sb_ff <= jac_pkg::SQ_TOP_BIT;
      end else if (cmd.sq_step) begin
         if (sq_ge) begin
            sx_ff <= sx_ff - sq_t[jac_pkg::SQ_W-1:0];
            sr_ff <= (sr_ff >> 1) + sb_ff;
         end else begin
            sr_ff <= sr_ff >> 1;
         end
         sb_ff <= sb_ff >> 2;
      end
   end

   // magnitude select
   assign rnd   = prod_ff + jac_pkg::ROUND_HALF;
   assign lin_q = qr_ff[jac_pkg::MAG_W-1:0];

   always_comb begin
      case (cmd.mag_src)
         jac_pkg::MAG_SRC_ZERO:  mag_in = '0;
         jac_pkg::MAG_SRC_FULL:  mag_in = jac_pkg::MAG_FULL;
         jac_pkg::MAG_SRC_LIN:   mag_in = (lin_q > jac_pkg::MAG_FULL) ? jac_pkg::MAG_FULL : lin_q;
         jac_pkg::MAG_SRC_ROUND: mag_in = rnd[jac_pkg::Q_BITS +: jac_pkg::MAG_W];
         default:                mag_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.mag_wr) begin
         mag_ff <= mag_in;
      end
   end

   // sign, inversion and change flag
   assign mag_s = jac_pkg::AXIS_W'(mag_ff);
   assign val_a = neg_ff ? -mag_s : mag_s;
   assign val   = cfg_flip_ff ? -val_a : val_a;

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         axis_ff    <= val;
         changed_ff <= val != last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff <= '0;
      end else if (cmd.out_load) begin
         last_ff <= val;
      end
   end

   assign rsp_axis_hundredths = axis_ff;
   assign rsp_changed         = changed_ff;

   // checks
   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |-> rem_ff < dv_ff)
      else $error("divider remainder not below divisor");

   a_root_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.rt_wr |-> sr_ff <= jac_pkg::SQ_W'(jac_pkg::QV_ONE))
      else $error("root above 1.0");

   a_axis_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> (axis_ff <= $signed(jac_pkg::AXIS_W'(jac_pkg::MAG_FULL))) &&
                       (axis_ff >= -$signed(jac_pkg::AXIS_W'(jac_pkg::MAG_FULL))))
      else $error("axis value out of range");

   a_changed_flag: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> rsp_changed == (axis_ff != $past(last_ff)))
      else $error("changed flag does not match previous value");

endmodule

FILE: design/joystick_axis_conditioner.sv
// ----------------------------------------------------------------------------
// joystick_axis_conditioner: one joystick axis, deadband / scale / expo
// Turns a raw ADC sample into a deflection in hundredths with change flag.
// ----------------------------------------------------------------------------
// One sample is worked at a time. A sample inside the deadband, on its edge,
// or at or beyond full scale skips the divider; the linear path runs the
// 7-step shift-subtract divider; with curve_power above 1.0 a sample runs
// the 24-step divider, square-and-multiply on one shared 25x25 multiplier
// and the eight 25-step square roots of the fraction bits of the exponent.
// A finished result sits in the output register while the next sample is
// taken in.
// Configuration writes are registered and must only be made while idle.
module joystick_axis_conditioner (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_we,
   input  logic [jac_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [jac_pkg::CSR_DATA_W-1:0]        csr_wdata,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [jac_pkg::SAMPLE_BITS-1:0]       req_sample,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [jac_pkg::AXIS_W-1:0]     rsp_axis_hundredths,
   output logic                                  rsp_changed
);

   jac_pkg::jac_cmd_type    cmd;
   jac_pkg::jac_status_type status;

   // sequencer
   jac_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // arithmetic and registers
   jac_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .req_sample          (req_sample),
      .cmd                 (cmd),
      .status              (status),
      .rsp_axis_hundredths (rsp_axis_hundredths),
      .rsp_changed         (rsp_changed)
   );

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: joystick axis conditioner check
// A directed table of samples is run first. Then randomized phases follow,
// each with its own calibration, deadband, expo and inversion settings.
// Every accepted sample goes through a behavioral copy of the conditioner.
// Each result beat is compared against the oldest predicted deflection.
// ----------------------------------------------------------------------------
module testbench;

   typedef struct {
      logic signed [jac_pkg::AXIS_W-1:0] axis;
      logic                              changed;
   } axis_result_type;

   typedef struct {
      logic [jac_pkg::SAMPLE_BITS-1:0]   sample;
      logic                              typed;
      logic signed [jac_pkg::AXIS_W-1:0] axis;
      logic                              changed;
   } sample_row_type;

   logic                                clock;
   logic                                reset;
   logic                                csr_we;
   logic [jac_pkg::CSR_IDX_W-1:0]       csr_index;
   logic [jac_pkg::CSR_DATA_W-1:0]      csr_wdata;
   logic                                req_valid;
   logic                                req_ready;
   logic [jac_pkg::SAMPLE_BITS-1:0]     req_sample;
   logic                                rsp_valid;
   logic                                rsp_ready;
   logic signed [jac_pkg::AXIS_W-1:0]   rsp_axis_hundredths;
   logic                                rsp_changed;

   // mirror of the block's settings and last output
   logic [jac_pkg::SAMPLE_BITS-1:0]     cal_min, cal_center, cal_max;
   logic [jac_pkg::DZ_BITS-1:0]         band_half;
   logic [jac_pkg::CURVE_BITS-1:0]      expo_power;
   logic                                invert;
   logic signed [jac_pkg::AXIS_W-1:0]   prev_axis;

   axis_result_type           pending_axis[$];
   int                        fail_count;
   int                        samples_sent;
   int                        results_seen;
   int                        expo_samples;
   logic                      calm;
   int                        stall_left;

   joystick_axis_conditioner DUT (
      .clock               (clock),
      .reset               (reset),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_sample          (req_sample),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_axis_hundredths (rsp_axis_hundredths),
      .rsp_changed         (rsp_changed)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // hard stop
   initial begin
      #40ms;
      $display("status: fail");
      $finish;
   end

   // integer square root, bit by bit
   function automatic logic [63:0] int_sqrt(input logic [63:0] x);
      logic [63:0] r;
      logic [63:0] b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x = x - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // m (Q24) raised to the Q3.8 power: integer part by squaring, then roots
   function automatic logic [63:0] expo_q24(input logic [63:0] m,
                                           input logic [jac_pkg::CURVE_BITS-1:0] pw);
      logic [63:0] acc;
      logic [63:0] base;
      logic [63:0] rt;
      int unsigned n;
      acc  = 64'd1 << jac_pkg::Q_BITS;
      base = m;
      rt   = m;
      n    = pw >> jac_pkg::CURVE_FRAC_BITS;
      while (n != 0) begin
         if (n[0]) acc = (acc * base) >> jac_pkg::Q_BITS;
         base = (base * base) >> jac_pkg::Q_BITS;
         n = n >> 1;
      end
      for (int i = jac_pkg::CURVE_FRAC_BITS - 1; i >= 0; i--) begin
         rt = int_sqrt(rt << jac_pkg::Q_BITS);
         if (pw[i]) acc = (acc * rt) >> jac_pkg::Q_BITS;
      end
      return acc;
   endfunction

   // deflection for one sample under the mirrored settings; updates last output
   function automatic axis_result_type condition_sample(
         input logic [jac_pkg::SAMPLE_BITS-1:0] s);
      longint sv, c, lo, hi, num, den, an, ad, h;
      int mag;
      logic neg;
      int val;
      logic [63:0] m, p;
      axis_result_type res;
      sv  = s;
      c   = cal_center;
      lo  = c - longint'(band_half);
      hi  = c + longint'(band_half);
      mag = 0;
      neg = 1'b0;
      if (!(sv > lo && sv < hi)) begin
         if (sv > c) begin
            num = sv - hi;
            den = longint'(cal_max) - hi;
         end else begin
            num = sv - lo;
            den = lo - longint'(cal_min);
         end
         if (num == 0) begin
            mag = 0;
         end else if (den == 0) begin
            mag = 100;
            neg = num < 0;
         end else begin
            neg = (num < 0) != (den < 0);
            an  = num < 0 ? -num : num;
            ad  = den < 0 ? -den : den;
            if (expo_power > jac_pkg::POWER_ONE) begin
               m = (64'(an) << jac_pkg::Q_BITS) / 64'(ad);
               if (m > (64'd1 << jac_pkg::Q_BITS)) m = 64'd1 << jac_pkg::Q_BITS;
               p = expo_q24(m, expo_power);
               mag = int'((p * 100 + (64'd1 << (jac_pkg::Q_BITS - 1))) >> jac_pkg::Q_BITS);
            end else begin
               h = (200 * an + ad) / (2 * ad);
               mag = h > 100 ? 100 : int'(h);
            end
            if (mag > 100) mag = 100;
         end
      end
      val = neg ? -mag : mag;
      if (invert) val = -val;
      res.axis    = jac_pkg::AXIS_W'(val);
      res.changed = (res.axis != prev_axis);
      prev_axis   = res.axis;
      return res;
   endfunction

   // gap length: mostly none or short, now and then long
   function automatic int pick_gap();
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // result side stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_ready  <= 1'b1;
         stall_left <= pick_gap();
      end
   end

   // compare each result beat with the oldest prediction
   always @(posedge clock) begin
      axis_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (pending_axis.size() == 0) begin
            $error("result beat with nothing predicted: axis_hundredths %0d",
                   rsp_axis_hundredths);
            fail_count++;
         end else begin
            want = pending_axis.pop_front();
            if (rsp_axis_hundredths !== want.axis) begin
               $error("axis_hundredths expected %0d actual %0d",
                      want.axis, rsp_axis_hundredths);
               fail_count++;
            end
            if (rsp_changed !== want.changed) begin
               $error("changed expected %0b actual %0b", want.changed, rsp_changed);
               fail_count++;
            end
         end
      end
   end

   // one sample beat; prediction is taken at acceptance
   task automatic send_sample(input logic [jac_pkg::SAMPLE_BITS-1:0] s, input logic typed,
                              input logic signed [jac_pkg::AXIS_W-1:0] t_axis,
                              input logic t_changed);
      int gap;
      axis_result_type res;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_sample <= s;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      res = condition_sample(s);
      if (expo_power > jac_pkg::POWER_ONE) expo_samples++;
      if (typed) begin
         res.axis    = t_axis;
         res.changed = t_changed;
      end
      pending_axis.push_back(res);
      samples_sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_axis.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // write all six registers back to back, block idle
   task automatic load_settings(input int mn, input int c, input int mx,
                                input int dz, input int pw, input int fl);
      int vals[6];
      jac_pkg::csr_index_type idx;
      vals = '{mn, c, mx, dz, pw, fl};
      for (int i = 0; i < 6; i++) begin
         idx = jac_pkg::csr_index_type'(i);
         csr_we    <= 1'b1;
         csr_index <= idx;
         csr_wdata <= jac_pkg::CSR_DATA_W'(vals[i]);
         case (idx)
            jac_pkg::CSR_AXIS_MIN:    cal_min    = jac_pkg::SAMPLE_BITS'(vals[i]);
            jac_pkg::CSR_AXIS_CENTER: cal_center = jac_pkg::SAMPLE_BITS'(vals[i]);
            jac_pkg::CSR_AXIS_MAX:    cal_max    = jac_pkg::SAMPLE_BITS'(vals[i]);
            jac_pkg::CSR_DEAD_ZONE:   band_half  = jac_pkg::DZ_BITS'(vals[i]);
            jac_pkg::CSR_CURVE_POWER: expo_power = jac_pkg::CURVE_BITS'(vals[i]);
            jac_pkg::CSR_FLIP_SIGN:   invert     = vals[i][0];
            default: ;
         endcase
         @(posedge clock);
      end
      csr_we <= 1'b0;
   endtask

   // sample biased toward band edges, calibration points and rails
   function automatic logic [jac_pkg::SAMPLE_BITS-1:0] pick_sample();
      int r;
      int pts[8];
      r = $urandom_range(0, 99);
      pts = '{0, 4095, int'(cal_center), int'(cal_center) - int'(band_half),
              int'(cal_center) + int'(band_half), int'(cal_min), int'(cal_max),
              int'(cal_center) + 1};
      if (r < 60) return jac_pkg::SAMPLE_BITS'($urandom_range(0, 4095));
      r = pts[$urandom_range(0, 7)] + $urandom_range(0, 2) - 1;
      if (r < 0) r = 0;
      if (r > 4095) r = 4095;
      return jac_pkg::SAMPLE_BITS'(r);
   endfunction

   sample_row_type plan[$];
   int phases;
   int mn, c, mx, dz, pw;

   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_valid = 1'b0;
      req_sample = '0;
      calm = 1'b0;
      fail_count = 0;
      samples_sent = 0;
      results_seen = 0;
      expo_samples = 0;
      cal_min = '0;
      cal_center = jac_pkg::CENTER_RESET;
      cal_max = jac_pkg::MAX_RESET;
      band_half = '0;
      expo_power = jac_pkg::POWER_ONE;
      invert = 1'b0;
      prev_axis = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: center, both rails, near-center and mid-range
      plan = '{'{12'd2048, 1'b1, 8'sd0, 1'b0},
               '{12'd4095, 1'b1, 8'sd100, 1'b1},
               '{12'd0,    1'b1, -8'sd100, 1'b1},
               '{12'd0,    1'b1, -8'sd100, 1'b0},
               '{12'd2047, 1'b0, 8'sd0, 1'b0},
               '{12'd2049, 1'b0, 8'sd0, 1'b0},
               '{12'd3071, 1'b0, 8'sd0, 1'b0}};
      foreach (plan[i]) send_sample(plan[i].sample, plan[i].typed, plan[i].axis,
                                    plan[i].changed);
      drain();

      // deadband with inversion: edges, inside, beyond calibration
      load_settings(100, 2000, 3900, 100, 256, 1);
      plan = '{'{12'd1900, 1'b0, 8'sd0, 1'b0}, '{12'd2100, 1'b0, 8'sd0, 1'b0},
               '{12'd1950, 1'b0, 8'sd0, 1'b0}, '{12'd0, 1'b0, 8'sd0, 1'b0},
               '{12'd4095, 1'b0, 8'sd0, 1'b0}, '{12'd2101, 1'b0, 8'sd0, 1'b0}};
      foreach (plan[i]) send_sample(plan[i].sample, 1'b0, 8'sd0, 1'b0);
      drain();

      // zero divisor on both sides
      load_settings(2048, 2048, 2048, 0, 256, 0);
      send_sample(12'd4095, 1'b1, 8'sd100, 1'b1);
      send_sample(12'd0, 1'b1, -8'sd100, 1'b1);
      drain();

      // reversed calibration, band past the lower rail, full expo
      load_settings(4095, 100, 0, 2047, 2047, 0);
      send_sample(12'd4095, 1'b0, 8'sd0, 1'b0);
      send_sample(12'd0, 1'b0, 8'sd0, 1'b0);
      send_sample(12'd3000, 1'b0, 8'sd0, 1'b0);
      drain();
      load_settings(0, 2048, 4095, 50, 512, 1);
      send_sample(12'd3000, 1'b0, 8'sd0, 1'b0);
      send_sample(12'd1000, 1'b0, 8'sd0, 1'b0);
      send_sample(12'd4095, 1'b0, 8'sd0, 1'b0);
      drain();

      // random phases
      phases = 0;
      while (samples_sent < 720) begin
         case (phases % 5)
            0: begin
               mn = $urandom_range(0, 300); mx = $urandom_range(3800, 4095);
               c = $urandom_range(1800, 2300); dz = $urandom_range(0, 150);
            end
            1: begin
               mn = $urandom_range(0, 4095); mx = $urandom_range(0, 4095);
               c = $urandom_range(0, 4095); dz = $urandom_range(0, 2047);
            end
            2: begin
               mn = 0; mx = 4095; c = $urandom_range(0, 1) ? 0 : 4095;
               dz = $urandom_range(0, 1) ? 2047 : 0;
            end
            default: begin
               mn = $urandom_range(0, 1000); mx = $urandom_range(3000, 4095);
               c = $urandom_range(1000, 3000); dz = $urandom_range(0, 400);
            end
         endcase
         case ($urandom_range(0, 5))
            0: pw = $urandom_range(0, 256);
            1: pw = 2047;
            2: pw = 257;
            default: pw = $urandom_range(257, 2047);
         endcase
         calm = (phases % 4 == 3);
         load_settings(mn, c, mx, dz, pw, $urandom_range(0, 1));
         for (int k = 0; k < 70; k++) begin
            send_sample(pick_sample(), 1'b0, 8'sd0, 1'b0);
            // sender holds off until everything is back
            if (k == 35 && phases % 3 == 0) drain();
         end
         drain();
         phases++;
      end
      calm = 1'b0;

      drain();
      repeat (20) @(posedge clock);
      $display("covered %0d samples (%0d through the expo curve), %0d results, %0d phases",
               samples_sent, expo_samples, results_seen, phases);
      if (fail_count == 0 && pending_axis.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

FILE: files.f
design/jac_pkg.sv
design/jac_ctrl.sv
design/jac_datapath.sv
design/joystick_axis_conditioner.sv
test/testbench.sv
